/* design/acr_pkg.sv */
// Shared types, constants and helpers for the box collision resolver.
`default_nettype none

package acr_pkg;

  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // Headroom for doubled centres, their difference and the corrected edge.
  localparam int WIDE_BITS  = COORD_BITS + 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SIZE_BITS-1:0]  dim_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic        [2:0]            side_t;

  localparam side_t SIDE_NONE   = 3'd0;
  localparam side_t SIDE_BOTTOM = 3'd1;
  localparam side_t SIDE_TOP    = 3'd2;
  localparam side_t SIDE_RIGHT  = 3'd3;
  localparam side_t SIDE_LEFT   = 3'd4;

  localparam wide_t COORD_MAX =
    $signed({{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam wide_t COORD_MIN =
    $signed({{(WIDE_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}});

  // Stage 1: sums of edges and sizes, mover and obstacle picked out.
  typedef struct packed {
    logic  ovl;
    logic  one_dyn;
    logic  m_b;
    wide_t mx;
    wide_t my;
    wide_t lx;
    wide_t ly;
    wide_t ox;
    wide_t oy;
    wide_t mx_end;
    wide_t my_end;
    wide_t ox_end;
    wide_t oy_end;
    wide_t lx_end;
    wide_t ly_end;
    wide_t cx2;
    wide_t cy2;
    wide_t ca_x;
    wide_t cb_x;
    wide_t ca_y;
    wide_t cb_y;
    wide_t sw;
    wide_t sh;
  } s1_t;

  // Stage 2: contact side chosen, absolute doubled centre distance.
  typedef struct packed {
    logic  ovl;
    logic  one_dyn;
    logic  m_b;
    side_t side;
    wide_t mx;
    wide_t my;
    wide_t adx;
    wide_t ady;
    wide_t sw;
    wide_t sh;
  } s2_t;

  // Stage 3: penetration on both axes.
  typedef struct packed {
    logic  ovl;
    logic  one_dyn;
    logic  m_b;
    side_t side;
    wide_t mx;
    wide_t my;
    wide_t px;
    wide_t py;
  } s3_t;

  function automatic wide_t sx(input coord_t v);
    return $signed({{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

  function automatic wide_t zx(input dim_t v);
    return $signed({{(WIDE_BITS-SIZE_BITS){1'b0}}, v});
  endfunction

  function automatic wide_t dbl(input wide_t v);
    return $signed({v[WIDE_BITS-2:0], 1'b0});
  endfunction

  function automatic coord_t sat_coord(input wide_t v);
    wide_t t;
    t = v;
    if (v > COORD_MAX) begin
      t = COORD_MAX;
    end else if (v < COORD_MIN) begin
      t = COORD_MIN;
    end
    return t[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/aabb_collide_resolve_top.sv */
// Top level of the box overlap test and penetration resolver pipeline.
`default_nettype none

// Takes one box pair per clock while in_stall is low.
// The four register stages are the strict-overlap test with the edge and
// centre sums, the contact-side compares with the centre distance, the
// halved penetration, and the pushed-out corner with saturation in the output
// register. A stall on the result side holds only the full stages: bubbles
// close up, and in_stall rises only when all four stages hold a beat.
// Coordinates are two's complement fixed point; the binary point does not
// matter, since only adds, compares and one floor halving are used.
module aabb_collide_resolve_top import acr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output      logic   in_stall,
  input  wire coord_t in_a_x,
  input  wire coord_t in_a_y,
  input  wire dim_t   in_a_w,
  input  wire dim_t   in_a_h,
  input  wire coord_t in_b_x,
  input  wire coord_t in_b_y,
  input  wire dim_t   in_b_w,
  input  wire dim_t   in_b_h,
  input  wire logic [1:0] in_static_pair,
  input  wire coord_t in_mover_last_x,
  input  wire coord_t in_mover_last_y,
  output      logic   out_valid,
  input  wire logic   out_stall,
  output      logic   out_overlap,
  output      logic   out_resolved,
  output      logic   out_mover_is_b,
  output      side_t  out_contact_side,
  output      coord_t out_corrected_x,
  output      coord_t out_corrected_y
);

  logic  v1_r, v2_r, v3_r, v4_r;
  logic  v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic  adv1, adv2, adv3, adv4;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  logic  ovl_r, ovl_nxt;
  logic  res_r, res_nxt;
  logic  mb_r, mb_nxt;
  side_t side_r, side_nxt;
  coord_t cx_r, cx_nxt;
  coord_t cy_r, cy_nxt;

  // A stage takes a new beat when it is empty or its beat moves on.
  assign adv4 = !v4_r || !out_stall;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;
  assign v3_nxt = adv3 ? v2_r : v3_r;
  assign v4_nxt = adv4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Stage 1.
  always_comb begin
    wide_t ax, ay, aw, ah, bx, by, bw, bh, mw, mh, ow, oh;
    ax = sx(in_a_x);
    ay = sx(in_a_y);
    aw = zx(in_a_w);
    ah = zx(in_a_h);
    bx = sx(in_b_x);
    by = sx(in_b_y);
    bw = zx(in_b_w);
    bh = zx(in_b_h);
    s1_nxt.ovl = !((ax + aw <= bx) || (ax >= bx + bw) ||
                   (ay + ah <= by) || (ay >= by + bh));
    s1_nxt.one_dyn = in_static_pair[0] ^ in_static_pair[1];
    s1_nxt.m_b = in_static_pair[0];
    s1_nxt.mx = s1_nxt.m_b ? bx : ax;
    s1_nxt.my = s1_nxt.m_b ? by : ay;
    mw = s1_nxt.m_b ? bw : aw;
    mh = s1_nxt.m_b ? bh : ah;
    s1_nxt.ox = s1_nxt.m_b ? ax : bx;
    s1_nxt.oy = s1_nxt.m_b ? ay : by;
    ow = s1_nxt.m_b ? aw : bw;
    oh = s1_nxt.m_b ? ah : bh;
    s1_nxt.lx = sx(in_mover_last_x);
    s1_nxt.ly = sx(in_mover_last_y);
    s1_nxt.mx_end = s1_nxt.mx + mw;
    s1_nxt.my_end = s1_nxt.my + mh;
    s1_nxt.ox_end = s1_nxt.ox + ow;
    s1_nxt.oy_end = s1_nxt.oy + oh;
    s1_nxt.lx_end = s1_nxt.lx + mw;
    s1_nxt.ly_end = s1_nxt.ly + mh;
    s1_nxt.cx2 = dbl(s1_nxt.ox) + ow;
    s1_nxt.cy2 = dbl(s1_nxt.oy) + oh;
    s1_nxt.ca_x = dbl(ax) + aw;
    s1_nxt.cb_x = dbl(bx) + bw;
    s1_nxt.ca_y = dbl(ay) + ah;
    s1_nxt.cb_y = dbl(by) + bh;
    s1_nxt.sw = aw + bw;
    s1_nxt.sh = ah + bh;
  end

  // Stage 2: the first matching side wins, bottom and top before right and left.
  always_comb begin
    logic  lix, liy;
    wide_t dx2, dy2;
    lix = (s1_r.lx_end > s1_r.ox) && (s1_r.lx < s1_r.ox_end);
    liy = (s1_r.ly_end > s1_r.oy) && (s1_r.ly < s1_r.oy_end);
    dx2 = s1_r.cb_x - s1_r.ca_x;
    dy2 = s1_r.cb_y - s1_r.ca_y;
    s2_nxt.ovl = s1_r.ovl;
    s2_nxt.one_dyn = s1_r.one_dyn;
    s2_nxt.m_b = s1_r.m_b;
    s2_nxt.mx = s1_r.mx;
    s2_nxt.my = s1_r.my;
    s2_nxt.sw = s1_r.sw;
    s2_nxt.sh = s1_r.sh;
    s2_nxt.adx = (dx2 < 0) ? -dx2 : dx2;
    s2_nxt.ady = (dy2 < 0) ? -dy2 : dy2;
    if (dbl(s1_r.ly_end) < s1_r.cy2 && s1_r.my_end >= s1_r.oy && !liy) begin
      s2_nxt.side = SIDE_BOTTOM;
    end else if (dbl(s1_r.ly) > s1_r.cy2 && s1_r.my <= s1_r.oy_end && !liy) begin
      s2_nxt.side = SIDE_TOP;
    end else if (dbl(s1_r.lx_end) < s1_r.cx2 && s1_r.mx_end >= s1_r.ox && !lix) begin
      s2_nxt.side = SIDE_RIGHT;
    end else if (dbl(s1_r.lx) > s1_r.cx2 && s1_r.mx < s1_r.ox_end && !lix) begin
      s2_nxt.side = SIDE_LEFT;
    end else begin
      s2_nxt.side = SIDE_NONE;
    end
  end

  // Stage 3: penetration is computed at double scale, then halved with floor.
  always_comb begin
    wide_t px2, py2;
    px2 = s2_r.sw - s2_r.adx;
    py2 = s2_r.sh - s2_r.ady;
    s3_nxt.ovl = s2_r.ovl;
    s3_nxt.one_dyn = s2_r.one_dyn;
    s3_nxt.m_b = s2_r.m_b;
    s3_nxt.side = s2_r.side;
    s3_nxt.mx = s2_r.mx;
    s3_nxt.my = s2_r.my;
    s3_nxt.px = px2 >>> 1;
    s3_nxt.py = py2 >>> 1;
  end

  // Stage 4: push the mover out and saturate.
  always_comb begin
    wide_t nx, ny;
    nx = s3_r.mx;
    ny = s3_r.my;
    case (s3_r.side)
      SIDE_BOTTOM: ny = s3_r.my - s3_r.py;
      SIDE_TOP:    ny = s3_r.my + s3_r.py;
      SIDE_RIGHT:  nx = s3_r.mx - s3_r.px;
      SIDE_LEFT:   nx = s3_r.mx + s3_r.px;
      default:     ;
    endcase
    ovl_nxt = s3_r.ovl;
    res_nxt = 1'b0;
    mb_nxt = 1'b0;
    side_nxt = SIDE_NONE;
    cx_nxt = '0;
    cy_nxt = '0;
    if (s3_r.ovl && s3_r.one_dyn) begin
      res_nxt = (s3_r.side != SIDE_NONE);
      mb_nxt = s3_r.m_b;
      side_nxt = s3_r.side;
      cx_nxt = sat_coord(nx);
      cy_nxt = sat_coord(ny);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r <= s1_nxt;
    end
    if (adv2) begin
      s2_r <= s2_nxt;
    end
    if (adv3) begin
      s3_r <= s3_nxt;
    end
    if (adv4) begin
      ovl_r <= ovl_nxt;
      res_r <= res_nxt;
      mb_r <= mb_nxt;
      side_r <= side_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_overlap = ovl_r;
  assign out_resolved = res_r;
  assign out_mover_is_b = mb_r;
  assign out_contact_side = side_r;
  assign out_corrected_x = cx_r;
  assign out_corrected_y = cy_r;

endmodule

`default_nettype wire

/* design/acr_checker.sv */
// Port-level checks for the box collision resolver, bound to its top level.
`default_nettype none

module acr_checker import acr_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_stall,
  input wire logic   out_valid,
  input wire logic   out_stall,
  input wire logic   out_overlap,
  input wire logic   out_resolved,
  input wire logic   out_mover_is_b,
  input wire side_t  out_contact_side,
  input wire coord_t out_corrected_x,
  input wire coord_t out_corrected_y
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_corrected_x) &&
    $stable(out_corrected_y) && $stable(out_contact_side))
    else $error("result beat changed while stalled");

  // The input backs up only when the pipeline is full behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overlap |-> !out_resolved && !out_mover_is_b &&
    out_contact_side == SIDE_NONE && out_corrected_x == '0 && out_corrected_y == '0)
    else $error("fields set without overlap");

  a_resolved_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_resolved == (out_contact_side != SIDE_NONE)))
    else $error("resolved flag disagrees with contact side");

  a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resolved |-> out_overlap && (out_contact_side == SIDE_BOTTOM ||
    out_contact_side == SIDE_TOP || out_contact_side == SIDE_RIGHT ||
    out_contact_side == SIDE_LEFT))
    else $error("bad contact side on a resolved beat");

endmodule

bind aabb_collide_resolve_top acr_checker u_acr_checker (.*);

`default_nettype wire

/* verif/aabb_collide_resolve_top_tb.sv */
// Testbench for the box overlap test and penetration resolver pipeline.
`timescale 1ns / 1ps

module aabb_collide_resolve_top_tb;
  import acr_pkg::*;

  localparam logic [1:0] BOTH_DYNAMIC = 2'b00;
  localparam logic [1:0] A_STATIC     = 2'b01;
  localparam logic [1:0] B_STATIC     = 2'b10;
  localparam logic [1:0] BOTH_STATIC  = 2'b11;

  localparam longint EDGE_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint EDGE_MIN = -(64'sd1 <<< (COORD_BITS - 1));
  localparam longint DIM_MAX  = (64'sd1 <<< SIZE_BITS) - 1;

  typedef struct packed {
    coord_t     a_x;
    coord_t     a_y;
    dim_t       a_w;
    dim_t       a_h;
    coord_t     b_x;
    coord_t     b_y;
    dim_t       b_w;
    dim_t       b_h;
    logic [1:0] static_pair;
    coord_t     last_x;
    coord_t     last_y;
  } box_pair_t;

  typedef struct packed {
    logic   overlap;
    logic   resolved;
    logic   mover_is_b;
    side_t  side;
    coord_t cx;
    coord_t cy;
  } contact_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid;
  logic       in_stall;
  coord_t     in_a_x, in_a_y, in_b_x, in_b_y;
  dim_t       in_a_w, in_a_h, in_b_w, in_b_h;
  logic [1:0] in_static_pair;
  coord_t     in_mover_last_x, in_mover_last_y;
  logic       out_valid;
  logic       out_stall;
  logic       out_overlap, out_resolved, out_mover_is_b;
  side_t      out_contact_side;
  coord_t     out_corrected_x, out_corrected_y;

  contact_t pending_contacts[$];
  int       mismatch_count = 0;
  bit       src_gaps_on = 1'b1;
  bit       sink_stall_on = 1'b1;

  aabb_collide_resolve_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_a_x           (in_a_x),
    .in_a_y           (in_a_y),
    .in_a_w           (in_a_w),
    .in_a_h           (in_a_h),
    .in_b_x           (in_b_x),
    .in_b_y           (in_b_y),
    .in_b_w           (in_b_w),
    .in_b_h           (in_b_h),
    .in_static_pair   (in_static_pair),
    .in_mover_last_x  (in_mover_last_x),
    .in_mover_last_y  (in_mover_last_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_overlap      (out_overlap),
    .out_resolved     (out_resolved),
    .out_mover_is_b   (out_mover_is_b),
    .out_contact_side (out_contact_side),
    .out_corrected_x  (out_corrected_x),
    .out_corrected_y  (out_corrected_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coord_t clamp_edge(input longint v);
    if (v > EDGE_MAX) begin
      return coord_t'(EDGE_MAX);
    end else if (v < EDGE_MIN) begin
      return coord_t'(EDGE_MIN);
    end
    return coord_t'(v);
  endfunction

  // Computes overlap, contact side and pushed-out corner for one box pair.
  function automatic contact_t predict_contact(input box_pair_t p);
    longint   ax, ay, aw, ah, bx, by, bw, bh, lx, ly;
    longint   mx, my, mw, mh, ox, oy, ow, oh;
    longint   cx2, cy2, dx2, dy2, px, py, nx, ny;
    bit       m_b, lix, liy;
    contact_t r;
    r  = '0;
    ax = p.a_x;
    ay = p.a_y;
    aw = p.a_w;
    ah = p.a_h;
    bx = p.b_x;
    by = p.b_y;
    bw = p.b_w;
    bh = p.b_h;
    lx = p.last_x;
    ly = p.last_y;
    if (ax + aw <= bx || ax >= bx + bw || ay + ah <= by || ay >= by + bh) begin
      return r;
    end
    r.overlap = 1'b1;
    if (p.static_pair == BOTH_DYNAMIC || p.static_pair == BOTH_STATIC) begin
      return r;
    end
    // Centres are kept at twice the scale so the distance stays exact.
    dx2 = (2 * bx + bw) - (2 * ax + aw);
    dy2 = (2 * by + bh) - (2 * ay + ah);
    px  = (aw + bw - (dx2 < 0 ? -dx2 : dx2)) >>> 1;
    py  = (ah + bh - (dy2 < 0 ? -dy2 : dy2)) >>> 1;
    m_b = (p.static_pair == A_STATIC);
    mx  = m_b ? bx : ax;
    my  = m_b ? by : ay;
    mw  = m_b ? bw : aw;
    mh  = m_b ? bh : ah;
    ox  = m_b ? ax : bx;
    oy  = m_b ? ay : by;
    ow  = m_b ? aw : bw;
    oh  = m_b ? ah : bh;
    cx2 = 2 * ox + ow;
    cy2 = 2 * oy + oh;
    lix = (lx + mw > ox) && (lx < ox + ow);
    liy = (ly + mh > oy) && (ly < oy + oh);
    nx  = mx;
    ny  = my;
    r.side = SIDE_NONE;
    if (2 * (ly + mh) < cy2 && my + mh >= oy && !liy) begin
      r.side = SIDE_BOTTOM;
      ny = my - py;
    end else if (2 * ly > cy2 && my <= oy + oh && !liy) begin
      r.side = SIDE_TOP;
      ny = my + py;
    end else if (2 * (lx + mw) < cx2 && mx + mw >= ox && !lix) begin
      r.side = SIDE_RIGHT;
      nx = mx - px;
    end else if (2 * lx > cx2 && mx < ox + ow && !lix) begin
      r.side = SIDE_LEFT;
      nx = mx + px;
    end
    r.resolved   = (r.side != SIDE_NONE);
    r.mover_is_b = m_b;
    r.cx         = clamp_edge(nx);
    r.cy         = clamp_edge(ny);
    return r;
  endfunction

  function automatic box_pair_t make_pair(input longint ax, ay, aw, ah, bx, by, bw, bh,
                                          input logic [1:0] st, input longint lx, ly);
    box_pair_t p;
    p.a_x         = coord_t'(ax);
    p.a_y         = coord_t'(ay);
    p.a_w         = dim_t'(aw);
    p.a_h         = dim_t'(ah);
    p.b_x         = coord_t'(bx);
    p.b_y         = coord_t'(by);
    p.b_w         = dim_t'(bw);
    p.b_h         = dim_t'(bh);
    p.static_pair = st;
    p.last_x      = coord_t'(lx);
    p.last_y      = coord_t'(ly);
    return p;
  endfunction

  // A mover overlapping (or just touching) an obstacle, with a previous
  // corner somewhere around it, so that every contact side gets reached.
  function automatic box_pair_t random_contact_pair();
    longint     lim, ox, oy, ow, oh, mx, my, mw, mh, lx, ly, vx, vy;
    int         pick;
    logic [1:0] st;
    lim = 64'sd1 <<< $urandom_range(1, 20);
    ow  = $urandom_range(1, int'(lim));
    oh  = $urandom_range(1, int'(lim));
    mw  = $urandom_range(1, int'(lim));
    mh  = $urandom_range(1, int'(lim));
    ox  = longint'($urandom_range(0, 1 << 23)) - (64'sd1 <<< 22);
    oy  = longint'($urandom_range(0, 1 << 23)) - (64'sd1 <<< 22);
    mx  = ox - mw + 1 + $urandom_range(0, int'(ow + mw - 2));
    my  = oy - mh + 1 + $urandom_range(0, int'(oh + mh - 2));
    // Now and then the boxes only touch, which is no overlap.
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      mx = ox + ow;
    end else if (pick == 1) begin
      mx = ox - mw;
    end else if (pick == 2) begin
      my = oy + oh;
    end else if (pick == 3) begin
      my = oy - mh;
    end
    vx = longint'($urandom_range(0, int'(2 * (mw + ow)))) - (mw + ow);
    vy = longint'($urandom_range(0, int'(2 * (mh + oh)))) - (mh + oh);
    lx = ($urandom_range(0, 4) == 0) ? mx : mx - vx;
    ly = ($urandom_range(0, 4) == 0) ? my : my - vy;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      st = BOTH_DYNAMIC;
    end else if (pick == 1) begin
      st = BOTH_STATIC;
    end else begin
      st = pick[0] ? A_STATIC : B_STATIC;
    end
    if (st == A_STATIC) begin
      return make_pair(ox, oy, ow, oh, mx, my, mw, mh, st, lx, ly);
    end
    return make_pair(mx, my, mw, mh, ox, oy, ow, oh, st, lx, ly);
  endfunction

  function automatic box_pair_t random_noise_pair();
    box_pair_t p;
    p.a_x         = coord_t'($urandom);
    p.a_y         = coord_t'($urandom);
    p.a_w         = dim_t'($urandom);
    p.a_h         = dim_t'($urandom);
    p.b_x         = coord_t'($urandom);
    p.b_y         = coord_t'($urandom);
    p.b_w         = dim_t'($urandom);
    p.b_h         = dim_t'($urandom);
    p.static_pair = 2'($urandom);
    p.last_x      = coord_t'($urandom);
    p.last_y      = coord_t'($urandom);
    return p;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sends one box pair and records its expected result once the beat is taken.
  task automatic send_pair(input box_pair_t p);
    int gap;
    bit took;
    gap = src_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_a_x          <= p.a_x;
    in_a_y          <= p.a_y;
    in_a_w          <= p.a_w;
    in_a_h          <= p.a_h;
    in_b_x          <= p.b_x;
    in_b_y          <= p.b_y;
    in_b_w          <= p.b_w;
    in_b_h          <= p.b_h;
    in_static_pair  <= p.static_pair;
    in_mover_last_x <= p.last_x;
    in_mover_last_y <= p.last_y;
    in_valid        <= 1'b1;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    pending_contacts.push_back(predict_contact(p));
  endtask

  task automatic wait_results_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_contacts.size() != 0 && guard < 20000);
    if (pending_contacts.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_contacts.size()));
    end
  endtask

  task automatic test_directed_edges();
    // Apart, touching on x, touching on y, and a zero-size box inside another.
    send_pair(make_pair(0, 0, 10, 10, 100, 100, 10, 10, B_STATIC, 0, 0));
    send_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10, B_STATIC, 0, 0));
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 10, B_STATIC, 0, 0));
    send_pair(make_pair(5, 5, 0, 0, 0, 0, 10, 10, B_STATIC, 5, 5));
    // Overlap with both boxes dynamic, then with both static.
    send_pair(make_pair(0, 0, 10, 10, 5, 5, 10, 10, BOTH_DYNAMIC, 0, 0));
    send_pair(make_pair(0, 0, 10, 10, 5, 5, 10, 10, BOTH_STATIC, 0, 0));
    // Contacts on every side, with A and B each taking a turn as the mover.
    send_pair(make_pair(50, 95, 20, 10, 0, 100, 200, 50, B_STATIC, 50, 80));
    send_pair(make_pair(0, 0, 200, 50, 50, 45, 20, 10, A_STATIC, 50, 60));
    send_pair(make_pair(95, 50, 10, 20, 100, 0, 50, 200, B_STATIC, 80, 50));
    send_pair(make_pair(0, 0, 50, 200, 45, 50, 10, 20, A_STATIC, 60, 50));
    send_pair(make_pair(0, 0, 200, 50, 50, 45, 20, 10, B_STATIC, 50, 60));
    send_pair(make_pair(0, 0, 7, 7, 5, 3, 8, 11, B_STATIC, -20, 0));
    // The mover already overlapped before, so no side is found.
    send_pair(make_pair(95, 50, 10, 20, 100, 0, 50, 200, B_STATIC, 95, 50));
    // Extreme corners and sizes.
    send_pair(make_pair(EDGE_MAX, EDGE_MAX, DIM_MAX, DIM_MAX, EDGE_MIN, EDGE_MIN,
                        DIM_MAX, DIM_MAX, B_STATIC, EDGE_MAX, EDGE_MAX));
    send_pair(make_pair(EDGE_MIN, EDGE_MIN, DIM_MAX, DIM_MAX, EDGE_MIN, EDGE_MIN,
                        DIM_MAX, DIM_MAX, B_STATIC, EDGE_MAX, EDGE_MAX));
    send_pair(make_pair(EDGE_MIN, EDGE_MIN, DIM_MAX, DIM_MAX, EDGE_MIN, EDGE_MIN,
                        DIM_MAX, DIM_MAX, A_STATIC, EDGE_MIN, EDGE_MIN));
    send_pair(make_pair(-1, -1, DIM_MAX, DIM_MAX, -100, -100, 200, 200, A_STATIC,
                        EDGE_MIN, 0));
    send_pair(make_pair(EDGE_MAX - 5, 0, 3, 3, EDGE_MAX - 4, 0, 4, 3, A_STATIC,
                        EDGE_MAX, 0));
  endtask

  task automatic test_random_contacts(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 8) begin
        send_pair(random_contact_pair());
      end else begin
        send_pair(random_noise_pair());
      end
    end
  endtask

  task automatic test_random_noise(input int count);
    repeat (count) send_pair(random_noise_pair());
  endtask

  // Beats back to back, first into a free sink, then into a stalling one.
  task automatic test_back_to_back(input int count);
    src_gaps_on   = 1'b0;
    sink_stall_on = 1'b0;
    test_random_contacts(count);
    sink_stall_on = 1'b1;
    test_random_contacts(count);
    src_gaps_on   = 1'b1;
  endtask

  initial begin
    int n;
    bit took;
    out_stall <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      n = sink_stall_on ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid && !out_stall;
        @(posedge clk);
      end while (!took);
    end
  end

  // Outputs are sampled at the falling edge; the beat is taken at the next rise.
  initial begin
    contact_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_contacts.size() == 0) begin
          note_mismatch("result beat with nothing expected");
        end else begin
          want = pending_contacts.pop_front();
          if (out_overlap !== want.overlap) begin
            note_mismatch($sformatf("overlap got %b want %b", out_overlap, want.overlap));
          end
          if (out_resolved !== want.resolved) begin
            note_mismatch($sformatf("resolved got %b want %b", out_resolved, want.resolved));
          end
          if (out_mover_is_b !== want.mover_is_b) begin
            note_mismatch($sformatf("mover_is_b got %b want %b",
                                    out_mover_is_b, want.mover_is_b));
          end
          if (out_contact_side !== want.side) begin
            note_mismatch($sformatf("contact_side got %0d want %0d",
                                    out_contact_side, want.side));
          end
          if (out_corrected_x !== want.cx) begin
            note_mismatch($sformatf("corrected_x got %0d want %0d",
                                    out_corrected_x, want.cx));
          end
          if (out_corrected_y !== want.cy) begin
            note_mismatch($sformatf("corrected_y got %0d want %0d",
                                    out_corrected_y, want.cy));
          end
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_valid        <= 1'b0;
    in_a_x          <= '0;
    in_a_y          <= '0;
    in_a_w          <= '0;
    in_a_h          <= '0;
    in_b_x          <= '0;
    in_b_y          <= '0;
    in_b_w          <= '0;
    in_b_h          <= '0;
    in_static_pair  <= BOTH_DYNAMIC;
    in_mover_last_x <= '0;
    in_mover_last_y <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    wait_results_drained();
    test_random_contacts(800);
    wait_results_drained();
    test_random_noise(250);
    wait_results_drained();
    test_back_to_back(150);
    wait_results_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* aabb_collide_resolve_top.f */
design/acr_pkg.sv
design/aabb_collide_resolve_top.sv
design/acr_checker.sv
verif/aabb_collide_resolve_top_tb.sv
